// File: rtl/ialu_pkg.sv
// Package for the integer ALU: operation codes, error codes and the control
// word that travels with each item. No dependencies.
`default_nettype none
package ialu_pkg;

  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_SUB   = 5'd1;
  localparam logic [4:0] OP_MUL   = 5'd2;
  localparam logic [4:0] OP_DIV   = 5'd3;
  localparam logic [4:0] OP_MOD   = 5'd4;
  localparam logic [4:0] OP_AND   = 5'd5;
  localparam logic [4:0] OP_OR    = 5'd6;
  localparam logic [4:0] OP_XOR   = 5'd7;
  localparam logic [4:0] OP_SAR   = 5'd8;
  localparam logic [4:0] OP_SHL   = 5'd9;
  localparam logic [4:0] OP_EQ    = 5'd10;
  localparam logic [4:0] OP_NE    = 5'd11;
  localparam logic [4:0] OP_LT    = 5'd12;
  localparam logic [4:0] OP_GT    = 5'd13;
  localparam logic [4:0] OP_LE    = 5'd14;
  localparam logic [4:0] OP_GE    = 5'd15;
  localparam logic [4:0] OP_LAND  = 5'd16;
  localparam logic [4:0] OP_LOR   = 5'd17;
  localparam logic [4:0] OP_NOT   = 5'd18;
  localparam logic [4:0] OP_NEG   = 5'd19;
  localparam logic [4:0] OP_LNOT  = 5'd20;
  localparam logic [4:0] OP_CE    = 5'd21;
  localparam logic [4:0] OP_CNE   = 5'd22;
  localparam logic [4:0] OP_CG    = 5'd23;
  localparam logic [4:0] OP_CGE   = 5'd24;
  localparam logic [4:0] OP_CL    = 5'd25;
  localparam logic [4:0] OP_CLE   = 5'd26;
  localparam logic [4:0] OP_CA    = 5'd27;
  localparam logic [4:0] OP_CAE   = 5'd28;
  localparam logic [4:0] OP_CB    = 5'd29;
  localparam logic [4:0] OP_CBE   = 5'd30;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_DIV0  = 2'd1;
  localparam logic [1:0] ERR_BADOP = 2'd2;

  typedef struct packed {
    logic       is_div;  // result comes from the divider chain
    logic       is_mod;  // take the remainder instead of the quotient
    logic       neg_q;   // negate the quotient at the end
    logic       neg_r;   // negate the remainder at the end
    logic [1:0] err;
  } ialu_ctl_t;

endpackage
`default_nettype wire

// File: rtl/ialu_if.sv
// Valid/ready channel interfaces for the integer ALU input and output.
// Depends on nothing.
`default_nettype none
interface ialu_in_if #(parameter int DATA_WIDTH = 32);
  logic                  valid;
  logic                  ready;
  logic [4:0]            op;
  logic [DATA_WIDTH-1:0] left;
  logic [DATA_WIDTH-1:0] right;
  modport source (output valid, op, left, right, input ready);
  modport sink   (input valid, op, left, right, output ready);
endinterface

interface ialu_out_if #(parameter int DATA_WIDTH = 32);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] result;
  logic [1:0]            error;
  modport source (output valid, result, error, input ready);
  modport sink   (input valid, result, error, output ready);
endinterface
`default_nettype wire

// File: rtl/ialu_front.sv
// Entry stage: decodes the operation, computes every result that needs no
// division (including the product) and prepares operand magnitudes for the divider.
// Depends on ialu_pkg.
`default_nettype none
module ialu_front
  import ialu_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output      logic                  ready_o,
  input  wire logic [4:0]            op_i,
  input  wire logic [DATA_WIDTH-1:0] left_i,
  input  wire logic [DATA_WIDTH-1:0] right_i,
  output      logic                  valid_o,
  input  wire logic                  ready_i,
  output      ialu_ctl_t             ctl_o,
  output      logic [DATA_WIDTH-1:0] dq_o,
  output      logic [DATA_WIDTH-1:0] dvs_o,
  output      logic [DATA_WIDTH-1:0] res_o
);
  localparam int SW = $clog2(DATA_WIDTH);

  logic                  valid_q;
  ialu_ctl_t             ctl_q, ctl_d;
  logic [DATA_WIDTH-1:0] dq_q, dq_d, dvs_q, dvs_d, res_q, res_d;
  logic [DATA_WIDTH-1:0] prod, mag_a, mag_b;
  logic [SW-1:0]         sh;
  logic                  neg_a, neg_b, slt, sgt, ult, ugt, eq, az, bz;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    neg_a = left_i[DATA_WIDTH-1];
    neg_b = right_i[DATA_WIDTH-1];
    mag_a = neg_a ? (~left_i + 1'b1) : left_i;
    mag_b = neg_b ? (~right_i + 1'b1) : right_i;
    prod  = left_i * right_i;
    sh    = right_i[SW-1:0];
    slt   = $signed(left_i) < $signed(right_i);
    sgt   = $signed(left_i) > $signed(right_i);
    ult   = left_i < right_i;
    ugt   = left_i > right_i;
    eq    = left_i == right_i;
    az    = left_i == '0;
    bz    = right_i == '0;
    ctl_d = '{is_div: 1'b0, is_mod: 1'b0, neg_q: neg_a ^ neg_b, neg_r: neg_a,
              err: ERR_OK};
    dq_d  = mag_a;
    dvs_d = mag_b;
    res_d = '0;
    case (op_i)
      OP_ADD:  res_d = left_i + right_i;
      OP_SUB:  res_d = left_i - right_i;
      OP_MUL:  res_d = prod;
      OP_DIV, OP_MOD: begin
        if (bz) begin
          ctl_d.err = ERR_DIV0;
        end else begin
          ctl_d.is_div = 1'b1;
          ctl_d.is_mod = (op_i == OP_MOD);
        end
      end
      OP_AND:  res_d = left_i & right_i;
      OP_OR:   res_d = left_i | right_i;
      OP_XOR:  res_d = left_i ^ right_i;
      OP_SAR:  res_d = $signed(left_i) >>> sh;
      OP_SHL:  res_d = left_i << sh;
      OP_EQ, OP_CE:   res_d[0] = eq;
      OP_NE, OP_CNE:  res_d[0] = !eq;
      OP_LT, OP_CL:   res_d[0] = slt;
      OP_GT, OP_CG:   res_d[0] = sgt;
      OP_LE, OP_CLE:  res_d[0] = !sgt;
      OP_GE, OP_CGE:  res_d[0] = !slt;
      OP_LAND: res_d[0] = !az && !bz;
      OP_LOR:  res_d[0] = !az || !bz;
      OP_NOT:  res_d = ~left_i;
      OP_NEG:  res_d = ~left_i + 1'b1;
      OP_LNOT: res_d[0] = az;
      OP_CA:   res_d[0] = ugt;
      OP_CAE:  res_d[0] = !ult;
      OP_CB:   res_d[0] = ult;
      OP_CBE:  res_d[0] = !ugt;
      default: ctl_d.err = ERR_BADOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctl_q <= ctl_d;
      dq_q  <= dq_d;
      dvs_q <= dvs_d;
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign dq_o    = dq_q;
  assign dvs_o   = dvs_q;
  assign res_o   = res_q;
endmodule
`default_nettype wire

// File: rtl/ialu_cell.sv
// One restoring-division cell: produces one quotient bit per item and hands
// the partial remainder and all other item data to the next cell.
// Depends on ialu_pkg.
`default_nettype none
module ialu_cell
  import ialu_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output      logic                  ready_o,
  input  wire ialu_ctl_t             ctl_i,
  input  wire logic [DATA_WIDTH-1:0] rem_i,
  input  wire logic [DATA_WIDTH-1:0] dq_i,
  input  wire logic [DATA_WIDTH-1:0] dvs_i,
  input  wire logic [DATA_WIDTH-1:0] res_i,
  output      logic                  valid_o,
  input  wire logic                  ready_i,
  output      ialu_ctl_t             ctl_o,
  output      logic [DATA_WIDTH-1:0] rem_o,
  output      logic [DATA_WIDTH-1:0] dq_o,
  output      logic [DATA_WIDTH-1:0] dvs_o,
  output      logic [DATA_WIDTH-1:0] res_o
);
  logic                  valid_q;
  ialu_ctl_t             ctl_q;
  logic [DATA_WIDTH-1:0] rem_q, rem_d, dq_q, dq_d, dvs_q, res_q;
  logic [DATA_WIDTH:0]   trial, diff;
  logic                  fits;

  assign ready_o = !valid_q || ready_i;

  // The dividend shifts out of the top of dq while quotient bits enter below.
  always_comb begin
    trial = {rem_i, dq_i[DATA_WIDTH-1]};
    diff  = trial - {1'b0, dvs_i};
    fits  = trial >= {1'b0, dvs_i};
    rem_d = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
    dq_d  = {dq_i[DATA_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctl_q <= ctl_i;
      rem_q <= rem_d;
      dq_q  <= dq_d;
      dvs_q <= dvs_i;
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign rem_o   = rem_q;
  assign dq_o    = dq_q;
  assign dvs_o   = dvs_q;
  assign res_o   = res_q;
endmodule
`default_nettype wire

// File: rtl/ialu_back.sv
// Output stage: applies the signs to quotient or remainder, picks the final
// result and holds it in the output register. Depends on ialu_pkg.
`default_nettype none
module ialu_back
  import ialu_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output      logic                  ready_o,
  input  wire ialu_ctl_t             ctl_i,
  input  wire logic [DATA_WIDTH-1:0] rem_i,
  input  wire logic [DATA_WIDTH-1:0] dq_i,
  input  wire logic [DATA_WIDTH-1:0] res_i,
  output      logic                  valid_o,
  input  wire logic                  ready_i,
  output      logic [DATA_WIDTH-1:0] result_o,
  output      logic [1:0]            error_o
);
  logic                  valid_q;
  logic [DATA_WIDTH-1:0] result_q, result_d, quo, rmd;
  logic [1:0]            error_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    quo      = ctl_i.neg_q ? (~dq_i + 1'b1) : dq_i;
    rmd      = ctl_i.neg_r ? (~rem_i + 1'b1) : rem_i;
    result_d = ctl_i.is_div ? (ctl_i.is_mod ? rmd : quo) : res_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_d;
      error_q  <= ctl_i.err;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;
  assign error_o  = error_q;
endmodule
`default_nettype wire

// File: rtl/integer_alu_32bit.sv
// Pipelined integer ALU. It accepts one operation per clock and passes each
// operation through one entry stage, a chain of DATA_WIDTH division cells that
// each settle one quotient bit, and the output register. Every operation
// travels the whole chain, so results leave in order. A stalled output holds
// the chain; stages still fill behind it, so the input keeps taking transfers
// until every stage is occupied. Shift counts use the low log2(DATA_WIDTH)
// bits of the right operand.
`default_nettype none
module integer_alu_32bit
  import ialu_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  ialu_in_if.sink   in_i,
  ialu_out_if.source out_o
);
  logic                  v   [0:DATA_WIDTH];
  logic                  rdy [0:DATA_WIDTH];
  ialu_ctl_t             ctl [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rem [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] dq  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] dvs [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] res [0:DATA_WIDTH];

  assign rem[0] = '0;

  ialu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .op_i    (in_i.op),
    .left_i  (in_i.left),
    .right_i (in_i.right),
    .valid_o (v[0]),
    .ready_i (rdy[0]),
    .ctl_o   (ctl[0]),
    .dq_o    (dq[0]),
    .dvs_o   (dvs[0]),
    .res_o   (res[0])
  );

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
    ialu_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[k]),
      .ready_o (rdy[k]),
      .ctl_i   (ctl[k]),
      .rem_i   (rem[k]),
      .dq_i    (dq[k]),
      .dvs_i   (dvs[k]),
      .res_i   (res[k]),
      .valid_o (v[k+1]),
      .ready_i (rdy[k+1]),
      .ctl_o   (ctl[k+1]),
      .rem_o   (rem[k+1]),
      .dq_o    (dq[k+1]),
      .dvs_o   (dvs[k+1]),
      .res_o   (res[k+1])
    );
  end

  ialu_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v[DATA_WIDTH]),
    .ready_o  (rdy[DATA_WIDTH]),
    .ctl_i    (ctl[DATA_WIDTH]),
    .rem_i    (rem[DATA_WIDTH]),
    .dq_i     (dq[DATA_WIDTH]),
    .res_i    (res[DATA_WIDTH]),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .result_o (out_o.result),
    .error_o  (out_o.error)
  );

  // The input can only stall when the whole chain is full behind a stalled output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without an output stall");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.error == ERR_OK || out_o.error == ERR_DIV0 ||
                     out_o.error == ERR_BADOP))
    else $error("illegal error code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.error != ERR_OK) |-> (out_o.result == '0))
    else $error("error result is not zero");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v[DATA_WIDTH] && rdy[DATA_WIDTH]) |=> out_o.valid)
    else $error("item lost at the output stage");
endmodule
`default_nettype wire

// File: tb/tb_pkg.sv
// Shared testbench types for the integer ALU bench: one stimulus row and one
// expected outcome. Depends on ialu_pkg.
`default_nettype none
package tb_pkg;
  import ialu_pkg::*;

  typedef struct packed {
    logic [4:0]  op;
    logic [31:0] left;
    logic [31:0] right;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] result;
    logic [1:0]  error;
  } alu_rsp_t;
endpackage
`default_nettype wire

// File: tb/testbench.sv
// Self-checking bench for integer_alu_32bit: a directed table of operations and
// edge operands, a sweep of OP_GE..OP_CBE, then random traffic with random gaps
// on both channels. Depends on ialu_pkg, ialu_if, tb_pkg and the RTL top level.
`default_nettype none
module testbench;
  import ialu_pkg::*;
  import tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 34;
  localparam int WATCHDOG  = 2000;
  localparam int N_RANDOM  = 1130;
  localparam logic [31:0] MIN_INT = 32'h8000_0000;
  localparam logic [31:0] MAX_INT = 32'h7fff_ffff;
  localparam logic [31:0] ALL_ONE = 32'hffff_ffff;
  // The one operation code that the block does not support.
  localparam logic [4:0]  OP_BADOP = 5'd31;

  logic clk_i;
  logic rst_ni;
  ialu_in_if  #(.DATA_WIDTH(32)) in_ch ();
  ialu_out_if #(.DATA_WIDTH(32)) out_ch ();

  integer_alu_32bit #(.DATA_WIDTH(32)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  alu_rsp_t pending_results[$];
  int       fail_count;
  int       idle_cycles;
  bit       stim_done;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit signed_less(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic alu_rsp_t alu_predict(alu_req_t req);
    alu_rsp_t    rsp;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    a = req.left;
    b = req.right;
    rsp.result = '0;
    rsp.error = ERR_OK;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    case (req.op)
      OP_ADD: rsp.result = a + b;
      OP_SUB: rsp.result = a - b;
      OP_MUL: rsp.result = a * b;
      OP_DIV, OP_MOD: begin
        if (b == '0) begin
          rsp.error = ERR_DIV0;
        end else if (req.op == OP_DIV) begin
          q = ma / mb;
          rsp.result = (a[31] != b[31]) ? -q : q;
        end else begin
          q = ma % mb;
          rsp.result = a[31] ? -q : q;
        end
      end
      OP_AND: rsp.result = a & b;
      OP_OR:  rsp.result = a | b;
      OP_XOR: rsp.result = a ^ b;
      OP_SAR: rsp.result = $signed(a) >>> b[4:0];
      OP_SHL: rsp.result = a << b[4:0];
      OP_EQ, OP_CE:   rsp.result = 32'(a == b);
      OP_NE, OP_CNE:  rsp.result = 32'(a != b);
      OP_LT, OP_CL:   rsp.result = 32'(signed_less(a, b));
      OP_GT, OP_CG:   rsp.result = 32'(signed_less(b, a));
      OP_LE, OP_CLE:  rsp.result = 32'(!signed_less(b, a));
      OP_GE, OP_CGE:  rsp.result = 32'(!signed_less(a, b));
      OP_LAND: rsp.result = 32'(a != '0 && b != '0);
      OP_LOR:  rsp.result = 32'(a != '0 || b != '0);
      OP_NOT:  rsp.result = ~a;
      OP_NEG:  rsp.result = -a;
      OP_LNOT: rsp.result = 32'(a == '0);
      OP_CA:   rsp.result = 32'(a > b);
      OP_CAE:  rsp.result = 32'(a >= b);
      OP_CB:   rsp.result = 32'(a < b);
      OP_CBE:  rsp.result = 32'(a <= b);
      default: rsp.error = ERR_BADOP;
    endcase
    return rsp;
  endfunction

  function automatic logic [31:0] random_operand();
    case ($urandom_range(9))
      0: return MIN_INT;
      1: return MAX_INT;
      2: return '0;
      3: return ALL_ONE;
      4: return 32'($urandom_range(40));
      5: return -32'($urandom_range(40));
      default: return $urandom();
    endcase
  endfunction

  function automatic int random_gap();
    if ($urandom_range(9) < 4) return 0;
    if ($urandom_range(19) == 0) return $urandom_range(60, 10);
    return $urandom_range(3, 1);
  endfunction

  task automatic send_op(alu_req_t req, bit has_golden, alu_rsp_t golden);
    alu_rsp_t model_rsp;
    in_ch.valid <= 1'b1;
    in_ch.op    <= req.op;
    in_ch.left  <= req.left;
    in_ch.right <= req.right;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    model_rsp = alu_predict(req);
    pending_results.push_back(has_golden ? golden : model_rsp);
  endtask

  // Directed rows: golden values given where obvious, else the predictor.
  typedef struct {
    alu_req_t req;
    bit       has_golden;
    alu_rsp_t golden;
  } dir_row_t;

  dir_row_t dir_table[] = '{
    '{'{OP_ADD, MAX_INT, 32'd1},       1, '{MIN_INT, ERR_OK}},
    '{'{OP_SUB, MIN_INT, 32'd1},       1, '{MAX_INT, ERR_OK}},
    '{'{OP_MUL, MIN_INT, ALL_ONE},     1, '{MIN_INT, ERR_OK}},
    '{'{OP_DIV, 32'd7, 32'd0},         1, '{32'd0, ERR_DIV0}},
    '{'{OP_MOD, MIN_INT, 32'd0},       1, '{32'd0, ERR_DIV0}},
    '{'{OP_DIV, MIN_INT, ALL_ONE},     1, '{MIN_INT, ERR_OK}},
    '{'{OP_MOD, MIN_INT, ALL_ONE},     1, '{32'd0, ERR_OK}},
    '{'{OP_DIV, -32'd7, 32'd2},        1, '{-32'd3, ERR_OK}},
    '{'{OP_MOD, -32'd7, 32'd2},        1, '{-32'd1, ERR_OK}},
    '{'{OP_AND, ALL_ONE, MAX_INT},     0, '0},
    '{'{OP_OR,  MIN_INT, 32'd5},       0, '0},
    '{'{OP_XOR, ALL_ONE, 32'h1234},    0, '0},
    '{'{OP_SAR, MIN_INT, 32'd31},      1, '{ALL_ONE, ERR_OK}},
    '{'{OP_SHL, 32'd1, 32'd33},        1, '{32'd2, ERR_OK}},
    '{'{OP_LT,  MIN_INT, MAX_INT},     1, '{32'd1, ERR_OK}},
    '{'{OP_LAND, 32'd0, ALL_ONE},      1, '{32'd0, ERR_OK}},
    '{'{OP_LOR,  32'd0, MIN_INT},      1, '{32'd1, ERR_OK}},
    '{'{OP_NOT,  32'd0, ALL_ONE},      1, '{ALL_ONE, ERR_OK}},
    '{'{OP_NEG,  MIN_INT, 32'd0},      1, '{MIN_INT, ERR_OK}},
    '{'{OP_LNOT, 32'd0, 32'd9},        1, '{32'd1, ERR_OK}},
    '{'{OP_CG,  MAX_INT, MIN_INT},     1, '{32'd1, ERR_OK}},
    '{'{OP_CA,  MAX_INT, MIN_INT},     1, '{32'd0, ERR_OK}},
    '{'{OP_CBE, ALL_ONE, ALL_ONE},     1, '{32'd1, ERR_OK}},
    '{'{OP_BADOP, ALL_ONE, ALL_ONE},   1, '{32'd0, ERR_BADOP}}
  };

  initial begin
    alu_req_t req;
    int       gap;
    fail_count  = 0;
    stim_done   = 1'b0;
    rst_ni      = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op    = '0;
    in_ch.left  = '0;
    in_ch.right = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_table[i]) begin
      send_op(dir_table[i].req, dir_table[i].has_golden, dir_table[i].golden);
    end
    // Every op code from OP_GE to OP_CBE, each once, with random operands.
    for (int op = OP_GE; op <= OP_CBE; op++) begin
      req = '{5'(op), random_operand(), random_operand()};
      send_op(req, 1'b0, '0);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      gap = random_gap();
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      req.op    = ($urandom_range(49) == 0) ? OP_BADOP : 5'($urandom_range(30));
      req.left  = random_operand();
      req.right = random_operand();
      send_op(req, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Output side: random stalls, then compare each transfer to the oldest entry.
  initial begin
    alu_rsp_t want;
    int       stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = random_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      if (out_ch.valid) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.result !== want.result) begin
            $error("result: expected %h, got %h", want.result, out_ch.result);
            fail_count++;
          end
          if (out_ch.error !== want.error) begin
            $error("error: expected %0d, got %0d", want.error, out_ch.error);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer, and the end of run.
  initial begin
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("integer_alu_32bit regression: fail");
        $finish;
      end
      if (stim_done && pending_results.size() == 0) break;
    end
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("integer_alu_32bit regression: pass");
    end else begin
      $display("integer_alu_32bit regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
rtl/ialu_pkg.sv
rtl/ialu_if.sv
rtl/ialu_front.sv
rtl/ialu_cell.sv
rtl/ialu_back.sv
rtl/integer_alu_32bit.sv
tb/tb_pkg.sv
tb/testbench.sv
